[sv/rmts_pkg.sv]
// Shared types and constants of the rate-monotonic tick scheduler.
package rmts_pkg;

  localparam int SEL_W = 6;                      // slot index room for up to 64 slots
  localparam int CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = 20'hFFFFF;

  localparam logic [2:0] EV_IDLE = 3'd0;
  localparam logic [2:0] EV_RAN  = 3'd1;
  localparam logic [2:0] EV_DONE = 3'd2;
  localparam logic [2:0] EV_MISS = 3'd3;
  localparam logic [2:0] EV_ALL  = 3'd4;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_REARM = 2'd2;

  localparam logic [1:0] REG_ACTIVE_TASKS = 2'd0;

  // Candidate handed along the cell chain during a scan.
  typedef struct packed {
    logic             any_jobs;
    logic             found;
    logic [SEL_W-1:0] sel;
    logic [15:0]      period;
    logic [15:0]      exec_time;
    logic [15:0]      time_left;
    logic [31:0]      release_time;
    logic [31:0]      deadline;
  } tok_t;

  // Slot load broadcast.
  typedef struct packed {
    logic             en;
    logic [SEL_W-1:0] slot;
    logic [15:0]      period;
    logic [15:0]      exec_time;
    logic [15:0]      job_count;
  } load_t;

  // Tick commit broadcast.
  typedef struct packed {
    logic             apply;
    logic [SEL_W-1:0] sel;
    logic [1:0]       op;
  } cmd_t;

endpackage

[sv/rmts_cell.sv]
// One task slot of the scheduler chain: slot state plus one scan stage.
module rmts_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [6:0]         n_use,
  input  logic [31:0]        now,
  input  rmts_pkg::load_t    ld,
  input  rmts_pkg::cmd_t     cmd,
  input  rmts_pkg::tok_t     tok_in,
  output rmts_pkg::tok_t     tok_out
);

  logic [15:0] period;
  logic [15:0] exec_time;
  logic [15:0] jobs_left;
  logic [31:0] release_time;
  logic [31:0] deadline;
  logic [15:0] time_left;
  logic        ready;

  logic        in_use;
  logic        due;
  logic        ready_eff;
  logic        take;
  logic        mine;
  logic [15:0] jobs_dec;
  rmts_pkg::tok_t tok_next;

  assign in_use    = 7'(INDEX) < n_use;
  assign due       = in_use && (jobs_left != 16'd0) && (release_time <= now);
  assign ready_eff = in_use && (ready || due);
  assign take      = ready_eff && (!tok_in.found || (period < tok_in.period));
  assign mine      = cmd.sel == rmts_pkg::SEL_W'(INDEX);
  assign jobs_dec  = (jobs_left != 16'd0) ? jobs_left - 16'd1 : jobs_left;

  always_comb begin
    tok_next = tok_in;
    tok_next.any_jobs = tok_in.any_jobs || (in_use && (jobs_left != 16'd0));
    if (take) begin
      tok_next.found        = 1'b1;
      tok_next.sel          = rmts_pkg::SEL_W'(INDEX);
      tok_next.period       = period;
      tok_next.exec_time    = exec_time;
      tok_next.time_left    = time_left;
      tok_next.release_time = release_time;
      tok_next.deadline     = deadline;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jobs_left    <= '0;
      release_time <= '0;
      ready        <= 1'b0;
    end else if (ld.en && ld.slot == rmts_pkg::SEL_W'(INDEX)) begin
      period       <= ld.period;
      exec_time    <= ld.exec_time;
      jobs_left    <= ld.job_count;
      release_time <= now;
      deadline     <= now + {16'd0, ld.period};
      time_left    <= ld.exec_time;
      ready        <= ld.job_count != 16'd0;
    end else if (cmd.apply) begin
      if (mine && cmd.op == rmts_pkg::OP_REARM) begin
        jobs_left <= jobs_dec;
        if (jobs_dec != 16'd0) begin
          release_time <= release_time + {16'd0, period};
          deadline     <= deadline + {16'd0, period};
        end
        time_left <= exec_time;
        ready     <= 1'b0;
      end else begin
        if (due)
          ready <= 1'b1;
        if (mine && cmd.op == rmts_pkg::OP_RUN)
          time_left <= time_left - 16'd1;
      end
    end
  end

endmodule

[sv/rate_monotonic_tick_scheduler.sv]
// Top level of the rate-monotonic tick scheduler: control, APB port and cell chain.
//
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   action task_slot period exec_time job_count
// out      source     out_valid/out_stall event_res task_res preempt preempted_task
//                                          wait_time now completed_total missed_total
// cfg      APB slave  psel/penable/pready active_tasks at byte address 0
//
// A load transfer makes no result.
// A tick: the candidate walks the slot chain one cell per cycle, then the commit edge
// loads the result register; the next input is taken only after the controller is
// back in idle.
// Commit waits while a previous result is still held by out_stall.
// Synchronous active-high reset clears slot job counts, ready flags, counters.
module rate_monotonic_tick_scheduler #(
  parameter int MAX_TASKS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [2:0]         task_slot,
  input  logic [15:0]        period,
  input  logic [15:0]        exec_time,
  input  logic [15:0]        job_count,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         event_res,
  output logic [2:0]         task_res,
  output logic               preempt,
  output logic [2:0]         preempted_task,
  output logic signed [31:0] wait_time,
  output logic [31:0]        now,
  output logic [19:0]        completed_total,
  output logic [19:0]        missed_total,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]  state;
  logic [CW-1:0] cnt;
  logic [3:0]  active_tasks;
  logic [31:0] tick_counter;
  logic [19:0] completed_count;
  logic [19:0] missed_count;
  logic        run_valid;
  logic [rmts_pkg::SEL_W-1:0] run_idx;

  logic [6:0]  n_use;
  logic        in_xfer;
  logic        commit;
  rmts_pkg::load_t ld;
  rmts_pkg::cmd_t  cmd;
  rmts_pkg::tok_t  tok [MAX_TASKS+1];
  rmts_pkg::tok_t  res;

  // APB: one register, always ready
  assign pready = 1'b1;
  assign prdata = {28'd0, active_tasks};

  always_ff @(posedge clk) begin
    if (rst)
      active_tasks <= 4'd1;
    else if (psel && penable && pwrite && paddr == rmts_pkg::REG_ACTIVE_TASKS)
      active_tasks <= pwdata[3:0];
  end

  assign n_use = ({3'd0, active_tasks} > 7'(MAX_TASKS)) ? 7'(MAX_TASKS)
                                                         : {3'd0, active_tasks};

  assign in_stall = state != ST_IDLE;
  assign in_xfer  = in_valid && !in_stall;

  // loads go straight to the cells; out-of-range slots are dropped
  always_comb begin
    ld.en        = in_xfer && !action && ({4'd0, task_slot} < 7'(MAX_TASKS));
    ld.slot      = rmts_pkg::SEL_W'(task_slot);
    ld.period    = period;
    ld.exec_time = exec_time;
    ld.job_count = job_count;
  end

  // chain head: empty candidate
  assign tok[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    rmts_cell #(.INDEX(g)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .n_use  (n_use),
      .now    (tick_counter),
      .ld     (ld),
      .cmd    (cmd),
      .tok_in (tok[g]),
      .tok_out(tok[g+1])
    );
  end

  assign res    = tok[MAX_TASKS];
  assign commit = (state == ST_COMMIT) && (!out_valid || !out_stall);

  // commit decision
  logic        miss;
  logic        done;
  logic [31:0] wait_next;
  logic [2:0]  ev_next;

  assign miss = res.deadline <= tick_counter;
  assign done = !miss && (res.time_left <= 16'd1);

  always_comb begin
    cmd.apply = commit && res.any_jobs;
    cmd.sel   = res.sel;
    cmd.op    = rmts_pkg::OP_NONE;
    ev_next   = rmts_pkg::EV_IDLE;
    wait_next = '0;
    if (!res.any_jobs) begin
      ev_next = rmts_pkg::EV_ALL;
    end else if (res.found) begin
      if (miss) begin
        ev_next   = rmts_pkg::EV_MISS;
        cmd.op    = rmts_pkg::OP_REARM;
        wait_next = tick_counter - res.release_time - {16'd0, res.exec_time}
                    + {16'd0, res.time_left};
      end else if (done) begin
        ev_next   = rmts_pkg::EV_DONE;
        cmd.op    = rmts_pkg::OP_REARM;
        wait_next = tick_counter + 32'd1 - res.release_time - {16'd0, res.exec_time};
      end else begin
        ev_next = rmts_pkg::EV_RAN;
        cmd.op  = rmts_pkg::OP_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cnt             <= '0;
      tick_counter    <= '0;
      completed_count <= '0;
      missed_count    <= '0;
      run_valid       <= 1'b0;
      run_idx         <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !commit)
        out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_xfer && action) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(MAX_TASKS - 1))
            state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            if (res.any_jobs) begin
              tick_counter <= tick_counter + 32'd1;
              if (res.found) begin
                if (miss || done)
                  run_valid <= 1'b0;
                else begin
                  run_valid <= 1'b1;
                  run_idx   <= res.sel;
                end
                if (miss && missed_count != rmts_pkg::CNT_MAX)
                  missed_count <= missed_count + 20'd1;
                if (done && completed_count != rmts_pkg::CNT_MAX)
                  completed_count <= completed_count + 20'd1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      event_res      <= ev_next;
      task_res       <= (res.any_jobs && res.found) ? res.sel[2:0] : 3'd0;
      preempt        <= res.any_jobs && res.found && run_valid && run_idx != res.sel;
      preempted_task <= (res.any_jobs && res.found && run_valid && run_idx != res.sel)
                        ? run_idx[2:0] : 3'd0;
      wait_time      <= wait_next;
      now            <= tick_counter;
      completed_total <= (res.any_jobs && res.found && done &&
                          completed_count != rmts_pkg::CNT_MAX)
                         ? completed_count + 20'd1 : completed_count;
      missed_total   <= (res.any_jobs && res.found && miss &&
                         missed_count != rmts_pkg::CNT_MAX)
                        ? missed_count + 20'd1 : missed_count;
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("input taken during a tick");
  a_completed_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> completed_count >= $past(completed_count))
    else $error("completed count went down");
  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> {1'b0, run_idx} < 7'(MAX_TASKS)) else $error("running slot out of range");
  a_all_done_hold: assert property (@(posedge clk) disable iff (rst)
    commit && !res.any_jobs |=> tick_counter == $past(tick_counter))
    else $error("tick advanced with all jobs done");
`endif

endmodule
